// ----- rtl/core/fvf_pkg.sv -----
// shared types, constants and filter arithmetic of the vertical filter block
package fvf_pkg;

   localparam int MAX_WIDTH_DEF = 2048;
   localparam int STORED_LINES  = 4;
   localparam int SLOT_W        = 2;
   localparam int ROW_W         = 12;
   localparam int VAL_W         = 13;
   localparam int DIV_W         = 21;
   localparam int MAX_HEIGHT    = 2048;
   localparam int ADDR_W        = 5;

   localparam logic [VAL_W-1:0] ONE_SCALE = 13'd8160;

   localparam logic [2:0] VIEW_INTERLACE = 3'd0;
   localparam logic [2:0] VIEW_DIFF      = 3'd1;
   localparam logic [2:0] VIEW_FIRST     = 3'd2;
   localparam logic [2:0] VIEW_SECOND    = 3'd3;
   localparam logic [2:0] VIEW_BLEND     = 3'd4;

   localparam logic [1:0] FILT_NONE  = 2'd0;
   localparam logic [1:0] FILT_THREE = 2'd1;
   localparam logic [1:0] FILT_FIVE  = 2'd2;
   localparam logic [1:0] FILT_FIVE2 = 2'd3;

   localparam logic [2:0] REG_VIEW   = 3'd0;
   localparam logic [2:0] REG_FILTER = 3'd1;
   localparam logic [2:0] REG_THRESH = 3'd2;
   localparam logic [2:0] REG_WIDTH  = 3'd3;
   localparam logic [2:0] REG_HEIGHT = 3'd4;

   localparam logic FUNC_PIXEL = 1'b0;
   localparam logic FUNC_DRAIN = 1'b1;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_RD   = 7'b0000010,
      S_WR   = 7'b0000100,
      S_TAP  = 7'b0001000,
      S_SEL  = 7'b0010000,
      S_DIV  = 7'b0100000,
      S_OUT  = 7'b1000000
   } state_type;

   typedef struct packed {
      logic             start;
      logic [VAL_W-1:0] alpha;
      logic [VAL_W-1:0] thresh;
   } lane_cmd_type;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic [7:0] alpha;
      logic       row_end;
      logic       frame_end;
   } rsp_item_type;

   function automatic logic [VAL_W-1:0] filt(input logic [1:0] mode,
                                              input logic [7:0] a2, input logic [7:0] a1,
                                              input logic [7:0] c, input logic [7:0] b1,
                                              input logic [7:0] b2);
      logic [9:0]  s3;
      logic [11:0] s5;
      logic [VAL_W-1:0] r;
      s3 = 10'(a1) + {1'b0, c, 1'b0} + 10'(b1);
      s5 = 12'(a2) + {2'b0, a1, 2'b0} + 12'(c) * 12'd6 + {2'b0, b1, 2'b0} + 12'(b2);
      case (mode)
         FILT_NONE:  r = {c, 5'b0};
         FILT_THREE: r = {s3, 3'b0};
         default:    r = {s5, 1'b0};
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/core/fvf_ram.sv -----
// generic single write port, single registered read port ram
module fvf_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/core/fvf_lane.sv -----
// one colour lane: unpremultiply by alpha with an iterative divider
module fvf_lane (
   input  logic                     clock,
   input  logic                     reset,
   input  fvf_pkg::lane_cmd_type    cmd,
   input  logic [fvf_pkg::VAL_W-1:0] value,
   output logic                     busy,
   output logic [7:0]               byte_out
);
   logic                          busy_ff, busy_in;
   logic [7:0]                    byte_ff, byte_in;
   logic [fvf_pkg::DIV_W-1:0]     rem_ff, rem_in;
   logic [fvf_pkg::VAL_W-1:0]     den_ff, den_in;
   logic [2:0]                    cnt_ff, cnt_in;
   logic [fvf_pkg::DIV_W-1:0]     shifted;

   always_comb begin
      busy_in = busy_ff;
      byte_in = byte_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      shifted = fvf_pkg::DIV_W'(den_ff) << cnt_ff;
      if (cmd.start) begin
         den_in = cmd.alpha;
         cnt_in = 3'd7;
         rem_in = (fvf_pkg::DIV_W'(value) << 8) - fvf_pkg::DIV_W'(value);
         if (cmd.alpha > cmd.thresh) begin
            if (value >= cmd.alpha) begin
               byte_in = 8'hFF;
            end else begin
               byte_in = 8'h00;
               busy_in = 1'b1;
            end
         end else begin
            byte_in = value[fvf_pkg::VAL_W-1 -: 8];
         end
      end else if (busy_ff) begin
         if (rem_ff >= shifted) begin
            rem_in          = rem_ff - shifted;
            byte_in[cnt_ff] = 1'b1;
         end
         cnt_in = cnt_ff - 3'd1;
         if (cnt_ff == 3'd0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      byte_ff <= byte_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      cnt_ff  <= cnt_in;
   end

   assign busy     = busy_ff;
   assign byte_out = byte_ff;
endmodule

// ----- rtl/core/fvf_merge.sv -----
// merges lane bytes into the packed pixel and holds the result beat
module fvf_merge (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  fvf_pkg::rsp_item_type item,
   output logic                  can_load,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,
   output logic                  rsp_tlast,
   output logic                  rsp_tuser
);
   logic        valid_ff, valid_in;
   logic [31:0] data_ff, data_in;
   logic        last_ff, last_in;
   logic        user_ff, user_in;

   assign can_load = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      user_in  = user_ff;
      if (valid_ff && rsp_tready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         data_in  = {item.blue, item.green, item.red, item.alpha};
         last_in  = item.row_end;
         user_in  = item.frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
      last_ff <= last_in;
      user_ff <= user_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = user_ff;
endmodule

// ----- rtl/core/field_view_vertical_filter_unpremul.sv -----
// top level: line stores, vertical filter, view select, unpremultiply lanes
//
//   channel | dir | beat contents
//   req_    | in  | tdata: two bgra pixels, tuser: drain tick
//   rsp_    | out | tdata: packed pixel, tlast: row end, tuser: frame end
//   csr_    | in  | apb register access
//
// an item without a result passes only accept and the store write state
// an item with a result adds read, tap, select, the 8-step lane divide and output
// one item is in work at a time; a finished beat waits in the output register
// synchronous reset clears counters and control registers, not data or line stores
module field_view_vertical_filter_unpremul #(
   parameter int MAX_WIDTH = fvf_pkg::MAX_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [63:0]                req_tdata,  // first b,g,r,a then second b,g,r,a
   input  logic                       req_tuser,  // func
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [31:0]                rsp_tdata,  // packed_pixel
   output logic                       rsp_tlast,  // row_end
   output logic                       rsp_tuser,  // frame_end
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [fvf_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int CMP_W = ((CW > 12) ? CW : 12) + 1;
   localparam int RW    = fvf_pkg::ROW_W;
   localparam int VW    = fvf_pkg::VAL_W;

   // configuration
   logic [2:0]  view_ff;
   logic [1:0]  filter_ff;
   logic [12:0] thresh_ff;
   logic [11:0] width_ff;
   logic [11:0] height_ff;
   logic        cfg_wr;

   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         view_ff   <= fvf_pkg::VIEW_INTERLACE;
         filter_ff <= fvf_pkg::FILT_NONE;
         thresh_ff <= 13'd0;
         width_ff  <= 12'd1920;
         height_ff <= 12'd1080;
      end else if (cfg_wr) begin
         unique case (csr_paddr[4:2])
            fvf_pkg::REG_VIEW:   view_ff   <= csr_pwdata[2:0];
            fvf_pkg::REG_FILTER: filter_ff <= csr_pwdata[1:0];
            fvf_pkg::REG_THRESH: thresh_ff <= csr_pwdata[12:0];
            fvf_pkg::REG_WIDTH:  width_ff  <= csr_pwdata[11:0];
            fvf_pkg::REG_HEIGHT: height_ff <= csr_pwdata[11:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         fvf_pkg::REG_VIEW:   csr_prdata = 32'(view_ff);
         fvf_pkg::REG_FILTER: csr_prdata = 32'(filter_ff);
         fvf_pkg::REG_THRESH: csr_prdata = 32'(thresh_ff);
         fvf_pkg::REG_WIDTH:  csr_prdata = 32'(width_ff);
         fvf_pkg::REG_HEIGHT: csr_prdata = 32'(height_ff);
         default:             csr_prdata = 32'd0;
      endcase
   end

   // counters and item context
   fvf_pkg::state_type state_ff, state_in;
   logic [CW-1:0] in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [RW-1:0] in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [CW-1:0] ox_ff, ox_in;
   logic [RW-1:0] oy_ff, oy_in, cur_row_ff, cur_row_in, eh_ff, eh_in;
   logic [63:0]   cur_ff, cur_in;
   logic          have_cur_ff, have_cur_in, res_ff, res_in, wr_ff, wr_in;
   logic          re_ff, re_in, fe_ff, fe_in;

   logic [CMP_W-1:0] ew;
   logic [RW-1:0]    eh;
   logic [CW-1:0]    ic, oc;
   logic [RW-1:0]    ir, orow;
   logic             in_last, out_last, accept;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == fvf_pkg::S_IDLE);

   always_comb begin
      if (width_ff == 12'd0) begin
         ew = CMP_W'(1);
      end else if (CMP_W'(width_ff) > CMP_W'(MAX_WIDTH)) begin
         ew = CMP_W'(MAX_WIDTH);
      end else begin
         ew = CMP_W'(width_ff);
      end
      if (height_ff == 12'd0) begin
         eh = RW'(1);
      end else if (height_ff > RW'(fvf_pkg::MAX_HEIGHT)) begin
         eh = RW'(fvf_pkg::MAX_HEIGHT);
      end else begin
         eh = height_ff;
      end
   end

   always_comb begin
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      ox_in       = ox_ff;
      oy_in       = oy_ff;
      cur_row_in  = cur_row_ff;
      eh_in       = eh_ff;
      cur_in      = cur_ff;
      have_cur_in = have_cur_ff;
      res_in      = res_ff;
      wr_in       = wr_ff;
      re_in       = re_ff;
      fe_in       = fe_ff;
      ic          = in_col_ff;
      ir          = in_row_ff;
      oc          = out_col_ff;
      orow        = out_row_ff;
      if (CMP_W'(in_col_ff) >= ew) begin
         ic = '0;
         ir = in_row_ff + RW'(1);
      end
      if (CMP_W'(out_col_ff) >= ew) begin
         oc   = '0;
         orow = out_row_ff + RW'(1);
      end
      in_last  = (CMP_W'(ic) == ew - CMP_W'(1));
      out_last = (CMP_W'(oc) == ew - CMP_W'(1));
      if (accept) begin
         in_col_in   = ic;
         in_row_in   = ir;
         res_in      = 1'b0;
         wr_in       = 1'b0;
         fe_in       = 1'b0;
         eh_in       = eh;
         cur_in      = {req_tdata[39:32], req_tdata[47:40], req_tdata[55:48],
                        req_tdata[63:56], req_tdata[7:0], req_tdata[15:8],
                        req_tdata[23:16], req_tdata[31:24]};
         cur_row_in  = ir;
         if (req_tuser == fvf_pkg::FUNC_PIXEL) begin
            have_cur_in = 1'b1;
            if (ir < eh) begin
               wr_in = 1'b1;
               ox_in = ic;
               oy_in = ir - RW'(2);
               re_in = in_last;
               if (ir >= RW'(2)) begin
                  res_in     = 1'b1;
                  out_col_in = in_last ? '0 : ic + CW'(1);
                  out_row_in = in_last ? ir - RW'(1) : ir - RW'(2);
               end
               in_col_in = in_last ? '0 : ic + CW'(1);
               in_row_in = in_last ? ir + RW'(1) : ir;
            end
         end else begin
            have_cur_in = 1'b0;
            if (ir >= eh) begin
               if (orow >= eh) begin
                  in_col_in  = '0;
                  in_row_in  = '0;
                  out_col_in = '0;
                  out_row_in = '0;
               end else begin
                  res_in = 1'b1;
                  ox_in  = oc;
                  oy_in  = orow;
                  re_in  = out_last;
                  fe_in  = out_last && (orow == eh - RW'(1));
                  if (out_last && (orow == eh - RW'(1))) begin
                     in_col_in  = '0;
                     in_row_in  = '0;
                     out_col_in = '0;
                     out_row_in = '0;
                  end else if (out_last) begin
                     out_col_in = '0;
                     out_row_in = orow + RW'(1);
                  end else begin
                     out_col_in = oc + CW'(1);
                     out_row_in = orow;
                  end
               end
            end
         end
      end
   end

   // line stores, one ram per row slot, both frames side by side
   logic [63:0] slot_rd [fvf_pkg::STORED_LINES];
   logic        store_wr;
   assign store_wr = (state_ff == fvf_pkg::S_WR) && wr_ff;

   for (genvar j = 0; j < fvf_pkg::STORED_LINES; j++) begin : g_store
      fvf_ram #(
         .WIDTH (64),
         .DEPTH (MAX_WIDTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (store_wr && (cur_row_ff[fvf_pkg::SLOT_W-1:0] == fvf_pkg::SLOT_W'(j))),
         .wr_addr (ox_ff),
         .wr_data (cur_ff),
         .rd_en   (state_ff == fvf_pkg::S_RD),
         .rd_addr (ox_ff),
         .rd_data (slot_rd[j])
      );
   end

   // tap gather
   logic [63:0]   tap_ff [5];
   logic [63:0]   tap_in [5];
   logic [RW-1:0] tap_row [5];

   always_comb begin
      for (int d = 0; d < 5; d++) begin
         if (d < 2) begin
            tap_row[d] = (oy_ff < RW'(2 - d)) ? '0 : oy_ff - RW'(2 - d);
         end else begin
            tap_row[d] = oy_ff + RW'(d - 2);
            if (tap_row[d] > eh_ff - RW'(1)) begin
               tap_row[d] = eh_ff - RW'(1);
            end
         end
         if (have_cur_ff && (tap_row[d] == cur_row_ff)) begin
            tap_in[d] = cur_ff;
         end else begin
            tap_in[d] = slot_rd[tap_row[d][fvf_pkg::SLOT_W-1:0]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == fvf_pkg::S_TAP) begin
         for (int d = 0; d < 5; d++) begin
            tap_ff[d] <= tap_in[d];
         end
      end
   end

   // filter and view select
   logic [VW-1:0] p1 [4];
   logic [VW-1:0] p2 [4];
   logic [VW-1:0] v  [4];
   logic [VW:0]   sum;
   logic [7:0]    alpha_ff, alpha_in;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         p1[k] = fvf_pkg::filt(filter_ff, tap_ff[0][31-8*k -: 8], tap_ff[1][31-8*k -: 8],
                               tap_ff[2][31-8*k -: 8], tap_ff[3][31-8*k -: 8],
                               tap_ff[4][31-8*k -: 8]);
         p2[k] = fvf_pkg::filt(filter_ff, tap_ff[0][63-8*k -: 8], tap_ff[1][63-8*k -: 8],
                               tap_ff[2][63-8*k -: 8], tap_ff[3][63-8*k -: 8],
                               tap_ff[4][63-8*k -: 8]);
         sum = {1'b0, p1[k]} + {1'b0, p2[k]};
         case (view_ff)
            fvf_pkg::VIEW_DIFF: begin
               if (k == 3) begin
                  v[k] = fvf_pkg::ONE_SCALE;
               end else begin
                  v[k] = (p1[k] > p2[k]) ? p1[k] - p2[k] : p2[k] - p1[k];
               end
            end
            fvf_pkg::VIEW_FIRST:  v[k] = p1[k];
            fvf_pkg::VIEW_SECOND: v[k] = p2[k];
            fvf_pkg::VIEW_BLEND:  v[k] = sum[VW:1];
            default:              v[k] = oy_ff[0] ? p2[k] : p1[k];
         endcase
      end
      alpha_in = (state_ff == fvf_pkg::S_SEL) ? v[3][VW-1 -: 8] : alpha_ff;
   end

   always_ff @(posedge clock) begin
      alpha_ff <= alpha_in;
   end

   // unpremultiply lanes
   fvf_pkg::lane_cmd_type lane_cmd;
   logic [2:0]            lane_busy;
   logic [7:0]            lane_byte [3];

   assign lane_cmd.start  = (state_ff == fvf_pkg::S_SEL);
   assign lane_cmd.alpha  = v[3];
   assign lane_cmd.thresh = thresh_ff;

   for (genvar k = 0; k < 3; k++) begin : g_lane
      fvf_lane u_lane (
         .clock    (clock),
         .reset    (reset),
         .cmd      (lane_cmd),
         .value    (v[k]),
         .busy     (lane_busy[k]),
         .byte_out (lane_byte[k])
      );
   end

   // merge
   fvf_pkg::rsp_item_type item;
   logic                  can_load, load;

   assign item.blue      = lane_byte[0];
   assign item.green     = lane_byte[1];
   assign item.red       = lane_byte[2];
   assign item.alpha     = alpha_ff;
   assign item.row_end   = re_ff;
   assign item.frame_end = fe_ff;
   assign load           = (state_ff == fvf_pkg::S_OUT) && can_load;

   fvf_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .item       (item),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fvf_pkg::S_IDLE: begin
            if (accept) begin
               state_in = res_in ? fvf_pkg::S_RD : fvf_pkg::S_WR;
            end
         end
         fvf_pkg::S_RD:  state_in = fvf_pkg::S_WR;
         fvf_pkg::S_WR:  state_in = res_ff ? fvf_pkg::S_TAP : fvf_pkg::S_IDLE;
         fvf_pkg::S_TAP: state_in = fvf_pkg::S_SEL;
         fvf_pkg::S_SEL: state_in = fvf_pkg::S_DIV;
         fvf_pkg::S_DIV: begin
            if (lane_busy == 3'b000) begin
               state_in = fvf_pkg::S_OUT;
            end
         end
         fvf_pkg::S_OUT: begin
            if (can_load) begin
               state_in = fvf_pkg::S_IDLE;
            end
         end
         default: state_in = fvf_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= fvf_pkg::S_IDLE;
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         res_ff     <= 1'b0;
         wr_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         res_ff     <= res_in;
         wr_ff      <= wr_in;
      end
      ox_ff       <= ox_in;
      oy_ff       <= oy_in;
      cur_row_ff  <= cur_row_in;
      eh_ff       <= eh_in;
      cur_ff      <= cur_in;
      have_cur_ff <= have_cur_in;
      re_ff       <= re_in;
      fe_ff       <= fe_in;
   end
endmodule

// ----- rtl/core/fvf_checker.sv -----
// port-level checks of the vertical filter block, bound to the top level
module fvf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result beat dropped while stalled");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result beat changed");

   a_frame_row: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("frame end without row end");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result beat right after reset");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second beat taken while busy");
endmodule

bind field_view_vertical_filter_unpremul fvf_checker u_fvf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
